// File: rtl/ipms_pkg.sv
// ----------------------------------------------------------------------------
// ipms_pkg
// shared types and constants of the incremental pid speed controller
// ----------------------------------------------------------------------------
package ipms_pkg;

    localparam int COUNT_W   = 32;
    localparam int TARGET_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 16;
    localparam int DZ_W      = 15;
    localparam int IDX_W     = 3;
    localparam int ERR_W     = 41;
    localparam int PROD_W    = 58;
    localparam int ACC_W     = 64;
    localparam int WIDE_W    = 72;
    localparam int INTEG_W   = 48;
    localparam int DIV_W     = 62;
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS = 62;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIVISOR    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRIVE_MIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DEAD_ZONE  = 3'd6;
    localparam logic [IDX_W-1:0] REG_ENABLE     = 3'd7;

    localparam logic signed [WIDE_W-1:0] SAT_LIM   = 72'sh00_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] INTEG_LIM = 72'sh00_0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic        [GAIN_W-1:0] prop_gain;
        logic        [GAIN_W-1:0] deriv_gain;
        logic        [GAIN_W-1:0] integ_gain;
        logic        [GAIN_W-1:0] output_divisor;
        logic signed [CFG_W-1:0]  drive_max;
        logic signed [CFG_W-1:0]  drive_min;
        logic        [DZ_W-1:0]   dead_zone;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic dis;
        logic prep;
        logic mul_p;
        logic mul_d;
        logic mul_i;
        logic sum1;
        logic sum2;
        logic div_step;
        logic fin1;
        logic fin2;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic logic signed [ACC_W-1:0] sat62(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > SAT_LIM) r = SAT_LIM;
        else if (v < -SAT_LIM) r = -SAT_LIM;
        return r[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/ipms_ctrl.sv
// ----------------------------------------------------------------------------
// ipms_ctrl
// sequencer that steps the datapath through one controller update
// ----------------------------------------------------------------------------
module ipms_ctrl
    import ipms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_enabled,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DIS    = 12'b0000_0000_0010,
        S_PREP   = 12'b0000_0000_0100,
        S_MUL_P  = 12'b0000_0000_1000,
        S_MUL_D  = 12'b0000_0001_0000,
        S_MUL_I  = 12'b0000_0010_0000,
        S_SUM1   = 12'b0000_0100_0000,
        S_SUM2   = 12'b0000_1000_0000,
        S_DIV    = 12'b0001_0000_0000,
        S_FIN1   = 12'b0010_0000_0000,
        S_FIN2   = 12'b0100_0000_0000,
        S_COMMIT = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) n_state = i_enabled ? S_PREP : S_DIS;
            end
            S_DIS: begin
                o_cmd.dis = 1'b1;
                n_state   = S_IDLE;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.mul_i = 1'b1;
                n_state     = S_SUM1;
            end
            S_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state    = S_SUM2;
            end
            S_SUM2: begin
                o_cmd.sum2 = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN1;
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// File: rtl/ipms_dp.sv
// ----------------------------------------------------------------------------
// ipms_dp
// pid datapath: shared multiplier, serial divider, loop state, result register
// ----------------------------------------------------------------------------
module ipms_dp
    import ipms_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int DRIVE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_cfg                          i_cfg,
    input  logic signed [COUNT_W-1:0]     i_encoder_count,
    input  logic signed [TARGET_W-1:0]    i_target_speed,
    input  logic                          i_out_stall,
    output t_sts                          o_sts,
    output logic                          o_out_valid,
    output logic signed [DRIVE_WIDTH-1:0] o_drive
);

    localparam int PD_W = CFG_W + FRAC_BITS;
    localparam int SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [WIDE_W-1:0] RND = (WIDE_W'(1) <<< SHR) - WIDE_W'(1);
    localparam int Q_W  = PD_W + DRIVE_WIDTH + 1;
    localparam logic signed [Q_W-1:0] QRND = (Q_W'(1) <<< FRAC_BITS) - Q_W'(1);

    logic signed [COUNT_W-1:0]  r_count, r_prev_count, r_speed, r_prev_speed;
    logic signed [TARGET_W-1:0] r_target;
    logic signed [ERR_W-1:0]    r_err, r_dsp;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_p, r_d, r_ip, r_pd, r_y;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [PD_W-1:0]     r_prev_drive, r_yc;
    logic                       r_hit, r_neg;
    logic [DIV_W-1:0]           r_dq;
    logic [GAIN_W-1:0]          r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_out_valid;
    logic signed [DRIVE_WIDTH-1:0] r_out_drive;

    logic signed [COUNT_W-1:0]  w_speed;
    logic [GAIN_W-1:0]          w_div;
    logic [GAIN_W:0]            w_trial;
    logic                       w_qbit;
    logic [GAIN_W-1:0]          w_gain;
    logic signed [ERR_W-1:0]    w_opnd;
    logic signed [ACC_W-1:0]    w_sum, w_abs, w_qs, w_dz, w_hi, w_lo, w_yd;
    logic signed [WIDE_W-1:0]   w_iv;
    logic signed [Q_W-1:0]      w_yq;

    function automatic logic signed [ACC_W-1:0] to_frac(input logic signed [PROD_W-1:0] v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (v < 0) w = w + RND;
        w = w >>> SHR;
        w = w <<< SHL;
        return sat62(w);
    endfunction

    assign w_speed = r_count - r_prev_count;
    assign w_div   = (i_cfg.output_divisor == '0) ? GAIN_W'(1) : i_cfg.output_divisor;
    assign w_trial = {r_rem, r_dq[DIV_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, w_div});

    always_comb begin
        w_gain = i_cfg.prop_gain;
        w_opnd = r_err;
        if (i_cmd.mul_d) begin
            w_gain = i_cfg.deriv_gain;
            w_opnd = r_dsp;
        end else if (i_cmd.mul_i) begin
            w_gain = i_cfg.integ_gain;
        end
    end

    assign w_sum = sat62(WIDE_W'(r_pd) + WIDE_W'(r_integ));
    assign w_abs = (w_sum < 0) ? -w_sum : w_sum;
    assign w_qs  = r_neg ? -$signed({2'b00, r_dq}) : $signed({2'b00, r_dq});
    assign w_dz  = $signed(ACC_W'(i_cfg.dead_zone) << FRAC_BITS);
    assign w_hi  = ACC_W'(i_cfg.drive_max) <<< FRAC_BITS;
    assign w_lo  = ACC_W'(i_cfg.drive_min) <<< FRAC_BITS;

    always_comb begin
        w_yd = r_y;
        if (!r_target[TARGET_W-1] && r_target != '0 && r_y > 0 && r_y < w_dz) begin
            w_yd = w_dz;
        end else if (r_target[TARGET_W-1] && r_y < 0 && r_y > -w_dz) begin
            w_yd = -w_dz;
        end
    end

    assign w_iv = WIDE_W'(r_integ) + WIDE_W'(r_ip);
    assign w_yq = (Q_W'(r_yc) + ((r_yc < 0) ? QRND : Q_W'(0))) >>> FRAC_BITS;

    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_drive        = r_out_drive;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count  <= i_encoder_count;
            r_target <= i_target_speed;
        end
        if (i_cmd.prep) begin
            r_speed <= w_speed;
            r_err   <= ERR_W'(r_target) - (ERR_W'(w_speed) <<< 8);
            r_dsp   <= (ERR_W'(w_speed) - ERR_W'(r_prev_speed)) <<< 8;
        end
        if (i_cmd.mul_p || i_cmd.mul_d || i_cmd.mul_i) begin
            r_prod <= PROD_W'($signed({1'b0, w_gain}) * w_opnd);
        end
        if (i_cmd.mul_d) r_p <= to_frac(r_prod);
        if (i_cmd.mul_i) r_d <= to_frac(r_prod);
        if (i_cmd.sum1) begin
            r_ip <= to_frac(r_prod);
            r_pd <= sat62(WIDE_W'(r_p) - WIDE_W'(r_d));
        end
        if (i_cmd.sum2) begin
            r_neg <= (w_sum < 0);
            r_dq  <= w_abs[DIV_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? GAIN_W'(w_trial - {1'b0, w_div}) : w_trial[GAIN_W-1:0];
            r_dq  <= {r_dq[DIV_W-2:0], w_qbit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.fin1) begin
            r_y <= sat62(WIDE_W'(w_qs) + WIDE_W'(r_prev_drive));
        end
        if (i_cmd.fin2) begin
            if (w_yd > w_hi) begin
                r_yc  <= PD_W'(w_hi);
                r_hit <= 1'b1;
            end else if (w_yd < w_lo) begin
                r_yc  <= PD_W'(w_lo);
                r_hit <= 1'b1;
            end else begin
                r_yc  <= PD_W'(w_yd);
                r_hit <= 1'b0;
            end
        end
        if (i_cmd.commit) r_out_drive <= w_yq[DRIVE_WIDTH-1:0];
    end

    // loop state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count <= '0;
            r_prev_speed <= '0;
            r_prev_drive <= '0;
            r_integ      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit)                     r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.dis && r_prev_speed != '0) begin
                r_prev_count <= r_count;
                r_prev_speed <= '0;
                r_prev_drive <= '0;
                r_integ      <= '0;
            end
            if (i_cmd.commit) begin
                r_prev_count <= r_count;
                r_prev_speed <= r_speed;
                r_prev_drive <= r_yc;
                if (!r_hit) begin
                    if (w_iv > INTEG_LIM)       r_integ <= INTEG_LIM[INTEG_W-1:0];
                    else if (w_iv < -INTEG_LIM) r_integ <= INTEG_W'(-INTEG_LIM);
                    else                        r_integ <= w_iv[INTEG_W-1:0];
                end
            end
        end
    end

endmodule

// File: rtl/incremental_pid_motor_speed.sv
// ----------------------------------------------------------------------------
// incremental_pid_motor_speed
// incremental pid speed loop with dead-zone lift, clamp and integral hold
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries one tick: the absolute
//   encoder count and the Q16.8 speed setpoint. output channel
//   (o_out_valid / i_out_stall) carries the drive value of that tick.
//   registers are written through i_cfg_we / i_cfg_index / i_cfg_data while
//   the block is idle; the user must keep to this, the block itself does not enforce it.
//   an enabled tick runs from acceptance through prep, mul_p, mul_d, mul_i,
//   sum1, sum2, the divider steps, fin1, fin2 and commit; the next tick is
//   taken only after commit. the sequence is set by the 62-step restoring
//   divider for output_divisor, the shared multiplier used three times and
//   the add/clamp stages. a tick taken while the loop is disabled gives no
//   transaction and stalls the input side only in the dis state.
//   a stalled result stays in the output register; the next tick is accepted
//   meanwhile and waits in its last stage until the register frees.
//   reset clears the loop state, loads register defaults, drops o_out_valid.
// ----------------------------------------------------------------------------
module incremental_pid_motor_speed
    import ipms_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int DRIVE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COUNT_W-1:0]     i_encoder_count,
    input  logic signed [TARGET_W-1:0]    i_target_speed,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [DRIVE_WIDTH-1:0] o_drive,
    input  logic                          i_cfg_we,
    input  logic [IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    t_cfg r_cfg;
    logic r_enabled;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= '0;
            r_cfg.deriv_gain     <= '0;
            r_cfg.integ_gain     <= '0;
            r_cfg.output_divisor <= GAIN_W'(1);
            r_cfg.drive_max      <= CFG_W'(255);
            r_cfg.drive_min      <= -CFG_W'(255);
            r_cfg.dead_zone      <= '0;
            r_enabled            <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP_GAIN:  r_cfg.prop_gain      <= i_cfg_data;
                REG_DERIV_GAIN: r_cfg.deriv_gain     <= i_cfg_data;
                REG_INTEG_GAIN: r_cfg.integ_gain     <= i_cfg_data;
                REG_DIVISOR:    r_cfg.output_divisor <= i_cfg_data;
                REG_DRIVE_MAX:  r_cfg.drive_max      <= i_cfg_data;
                REG_DRIVE_MIN:  r_cfg.drive_min      <= i_cfg_data;
                REG_DEAD_ZONE:  r_cfg.dead_zone      <= i_cfg_data[DZ_W-1:0];
                REG_ENABLE:     r_enabled            <= i_cfg_data[0];
                default:        r_enabled            <= r_enabled;
            endcase
        end
    end

    ipms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_enabled  (r_enabled),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    ipms_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .DRIVE_WIDTH (DRIVE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (r_cfg),
        .i_encoder_count (i_encoder_count),
        .i_target_speed  (i_target_speed),
        .i_out_stall     (i_out_stall),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_drive         (o_drive)
    );

endmodule

// File: rtl/ipms_checker.sv
// ----------------------------------------------------------------------------
// ipms_checker
// port-level checks of the speed controller, bound to the top level
// ----------------------------------------------------------------------------
module ipms_checker #(
    parameter int DRIVE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [DRIVE_WIDTH-1:0] o_drive
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive))
        else $error("stalled result changed");

    // one transaction at a time on the input side
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while busy");

    // a result never appears right after an input transaction
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

    // reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset state wrong");

endmodule

bind incremental_pid_motor_speed ipms_checker #(
    .DRIVE_WIDTH (DRIVE_WIDTH)
) u_ipms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive)
);

// File: tb/incremental_pid_motor_speed_tb.sv
// ----------------------------------------------------------------------------
// incremental_pid_motor_speed_tb
// checks the pid speed loop drive values against a cycle-free predictor
// ----------------------------------------------------------------------------
// each accepted tick is run through a predictor with its own copy of the loop
// state and registers; the predicted drive is queued and every output
// transaction is compared with the oldest entry. registers are rewritten only
// when the block is idle. idling on both channels is varied per phase.
// ----------------------------------------------------------------------------
module incremental_pid_motor_speed_tb;
    import ipms_pkg::*;

    localparam longint SAT = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint ILIM = 64'sh0000_7FFF_FFFF_FFFF;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [COUNT_W-1:0] i_encoder_count = '0;
    logic signed [TARGET_W-1:0] i_target_speed = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [15:0] o_drive;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    incremental_pid_motor_speed u_dut (.*);

    initial forever #2 i_clk = ~i_clk;

    // predictor state and registers
    longint kp, kd, ki, kdiv, dmax, dmin, dz;
    bit en;
    logic [31:0] last_count;
    longint last_speed, last_drive, integ;

    logic signed [15:0] drive_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_recv = 1'b0;

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return clip(clip(a, SAT) + clip(b, SAT), SAT);
    endfunction

    task automatic predict_drive(logic [31:0] cnt, logic signed [23:0] tgt);
        longint t, speed, err, dsp, p, d, s, y, hi, lo, dzl, dv;
        t = tgt;
        if (!en) begin
            if (last_speed != 0) begin
                integ = 0;
                last_count = cnt;
                last_speed = 0;
                last_drive = 0;
            end
            return;
        end
        speed = longint'($signed(cnt - last_count));
        err = t - speed * 256;
        dsp = (speed - last_speed) * 256;
        p = kp * err;
        d = kd * dsp;
        s = sat_add(sat_add(p, -d), integ);
        dv = (kdiv == 0) ? 1 : kdiv;
        y = sat_add(s / dv, last_drive);
        dzl = dz * 65536;
        if (t > 0 && y > 0 && y < dzl) y = dzl;
        else if (t < 0 && y < 0 && y > -dzl) y = -dzl;
        hi = dmax * 65536;
        lo = dmin * 65536;
        if (y > hi) y = hi;
        else if (y < lo) y = lo;
        else integ = clip(integ + ki * err, ILIM);
        drive_q.push_back(16'(y / 65536));
        last_count = cnt;
        last_speed = speed;
        last_drive = y;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN: kp = val;
            REG_DERIV_GAIN: kd = val;
            REG_INTEG_GAIN: ki = val;
            REG_DIVISOR: kdiv = val;
            REG_DRIVE_MAX: dmax = longint'($signed(val));
            REG_DRIVE_MIN: dmin = longint'($signed(val));
            REG_DEAD_ZONE: dz = val[DZ_W-1:0];
            REG_ENABLE: en = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        wait (drive_q.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_tick(logic [31:0] cnt, logic signed [23:0] tgt);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_encoder_count <= cnt;
        i_target_speed <= tgt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_drive(cnt, tgt);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_loop(logic [15:0] p, logic [15:0] d, logic [15:0] i,
                            logic [15:0] dv, logic [15:0] mx, logic [15:0] mn,
                            logic [15:0] z, bit e);
        drain();
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DIVISOR, dv);
        write_reg(REG_DRIVE_MAX, mx);
        write_reg(REG_DRIVE_MIN, mn);
        write_reg(REG_DEAD_ZONE, z);
        write_reg(REG_ENABLE, 16'(e));
    endtask

    // directed corners: field extremes, dead zone, crossed limits, disable
    task automatic test_directed();
        logic [31:0] c;
        set_loop(16'h0100, 16'h0040, 16'h0010, 16'd1, 16'd255, -16'sd255, 16'd0, 1'b1);
        c = '0;
        send_tick(c, 24'sh7FFFFF);
        send_tick(c + 32'h7FFFFFFF, 24'sh800000);
        send_tick(32'h80000000, 24'sh000000);
        send_tick(32'hFFFFFFFF, 24'shFFFFFF);
        send_tick(32'h00000000, 24'sh000100);
        set_loop(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
        send_tick(32'h12345678, 24'sh7FFFFF);
        send_tick(32'h00000000, 24'sh800000);
        send_tick(32'h7FFFFFFF, 24'sh000001);
        send_tick(32'h80000000, 24'shFFFFFF);
        set_loop(16'h0001, 16'd0, 16'd0, 16'hFFFF, 16'd100, -16'sd100, 16'd40, 1'b1);
        send_tick(32'd0, 24'sd256);
        send_tick(32'd0, -24'sd256);
        send_tick(32'd5, 24'sd1);
        // crossed limits: upper test wins
        set_loop(16'h0200, 16'd0, 16'd0, 16'd1, -16'sd10, 16'd10, 16'd0, 1'b1);
        send_tick(32'd0, 24'sh010000);
        send_tick(32'd0, -24'sh010000);
        send_tick(32'd0, 24'sd0);
        // disabled ticks: clear only on nonzero previous speed (zero here), then nothing
        set_loop(16'h0100, 16'd0, 16'h0100, 16'd1, 16'd255, -16'sd255, 16'd0, 1'b0);
        send_tick(32'd1000, 24'sd0);
        send_tick(32'd2000, 24'sd0);
        drain();
        write_reg(REG_ENABLE, 16'd1);
        send_tick(32'd2010, 24'sd2560);
        send_tick(32'd2020, 24'sd2560);
    endtask

    function automatic logic [15:0] rand_limit(bit pos);
        case ($urandom_range(3))
            0: return pos ? 16'h7FFF : 16'h8000;
            1: return 16'($urandom);
            default: return pos ? 16'($urandom_range(2000)) : 16'(-$urandom_range(2000));
        endcase
    endfunction

    // random: mostly smooth speed profiles, some wild counts and disable noise
    task automatic test_random(int n);
        logic [31:0] c;
        int speed;
        c = $urandom;
        for (int k = 0; k < n; k++) begin
            if (k % 150 == 0) begin
                set_loop(16'($urandom_range(4) == 0 ? $urandom : $urandom_range(1024)),
                         16'($urandom_range(4) == 0 ? $urandom : $urandom_range(512)),
                         16'($urandom_range(4) == 0 ? $urandom : $urandom_range(64)),
                         16'($urandom_range(5) == 0 ? $urandom : $urandom_range(4)),
                         rand_limit(1), rand_limit(0),
                         16'($urandom_range(3) == 0 ? $urandom : $urandom_range(50)),
                         $urandom_range(9) != 0);
                speed = $urandom_range(400) - 200;
            end
            if ($urandom_range(19) == 0) c = $urandom;
            else c = c + 32'(speed + int'($urandom_range(6)) - 3);
            if ($urandom_range(9) == 0) send_tick(c, 24'($urandom));
            else send_tick(c, 24'((speed + int'($urandom_range(20)) - 10) * 256));
        end
    endtask

    // receiver holds off while the sender keeps offering ticks, then sender waits for all
    task automatic test_pressure();
        set_loop(16'h0100, 16'h0010, 16'h0008, 16'd2, 16'd500, -16'sd500, 16'd5, 1'b1);
        hold_recv = 1'b1;
        for (int k = 0; k < 6; k++) send_tick(32'(k * 37), 24'(k * 4000));
        drain();
    endtask

    initial begin
        kp = 0; kd = 0; ki = 0; kdiv = 1; dmax = 255; dmin = -255; dz = 0; en = 0;
        last_count = 0; last_speed = 0; last_drive = 0; integ = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 38; recv_idle = 46;
        test_directed();
        test_random(620);
        test_pressure();
        send_idle = 46; recv_idle = 38;
        test_random(620);
        send_idle = 0; recv_idle = 0;
        test_random(620);
        drain();
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // receiver stall: random idling plus one long hold-off
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_recv && hold == 0) begin
                hold = 600;
                hold_recv = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // result check against the oldest predicted drive
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_q.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual %0d",
                         $time, o_drive);
                errors++;
            end else begin
                if (o_drive !== drive_q[0]) begin
                    $display("%0t drive mismatch: expected %0d, actual %0d",
                             $time, drive_q[0], o_drive);
                    errors++;
                end
                void'(drive_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction on either channel, no register write and work pending
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we
            || (drive_q.size() == 0 && !i_in_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/ipms_pkg.sv
rtl/ipms_ctrl.sv
rtl/ipms_dp.sv
rtl/incremental_pid_motor_speed.sv
rtl/ipms_checker.sv
tb/incremental_pid_motor_speed_tb.sv
